@@ src/kal_pkg.sv @@
// ----------------------------------------------------------------------------
// kal_pkg
// Shared constants and controller/datapath interface types for the k-th
// ancestor block.
// ----------------------------------------------------------------------------
`default_nettype none

package kal_pkg;

  localparam int NODES    = 65536;
  localparam int LEVELS   = 16;
  localparam int ID_W     = 16;
  localparam int ADDR_W   = $clog2(NODES);
  localparam int LVL_W    = $clog2(LEVELS);
  localparam int JT_DEPTH = NODES * (2 ** LVL_W);

  typedef struct packed {
    logic clr_wr;
    logic ld_wr;
    logic query_latch;
    logic cnt_clear;
    logic cnt_inc;
    logic lvl_clear;
    logic lvl_inc;
    logic copy_issue;
    logic lift_issue;
    logic walk_issue;
    logic walk_take;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic node_ok;
    logic is_query;
    logic cnt_last;
    logic lvl_last;
    logic pipe_empty;
    logic k_bit;
    logic miss;
    logic rd_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ src/kth_ancestor_binary_lifting.sv @@
// ----------------------------------------------------------------------------
// kth_ancestor_binary_lifting
// K-th ancestor queries over a parent forest by binary lifting.
//
// Request channel (req_valid/req_stall): op 0 loads the parent of node
// (value, 0 = root) and produces no response; op 1 queries the
// value-th ancestor of node. Response channel (rsp_valid/rsp_stall) carries
// ancestor and found, one transfer per query.
// A query on a clean table holds the request channel from its transfer to
// the next request transfer: it walks the bits of k from level 0 up, each
// set bit issuing a registered read of the jump table memory and taking its
// result, stops early on a miss, and then loads the result.
// The first query after reset or after any load of a valid node rebuilds
// the table first: a copy sweep over NODES entries for level 0, then
// LEVELS-1 lift sweeps over NODES entries, each sweep followed by a drain.
// After reset the parent store is cleared, one entry a cycle, over all
// NODES entries (65536); req_stall stays high until the clear is done.
// One request is in flight at a time. The result sits in an output register;
// a stalled response holds, and a finished query waits for the register to
// free before the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module kth_ancestor_binary_lifting (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic        op,
  input  wire logic [15:0] node,
  input  wire logic [15:0] value,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [15:0]      ancestor,
  output logic             found
);
  import kal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  kal_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .op        (op),
    .node      (node),
    .value     (value),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ancestor  (ancestor),
    .found     (found)
  );

endmodule

`default_nettype wire

@@ src/kal_dp.sv @@
// ----------------------------------------------------------------------------
// kal_dp
// Datapath: parent store, jump table memory, rebuild pipeline, query walk
// registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kal_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kal_pkg::cmd_t     cmd,
  output kal_pkg::sts_t          sts,
  input  wire logic              op,
  input  wire logic [15:0]       node,
  input  wire logic [15:0]       value,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output logic [15:0]            ancestor,
  output logic                   found
);
  import kal_pkg::*;

  logic [ID_W-1:0]        parent_mem [NODES];
  logic [ID_W-1:0]        jt_mem [JT_DEPTH];

  logic [ADDR_W-1:0]      cnt;
  logic [LVL_W-1:0]       lvl;
  logic [LVL_W-1:0]       lvl_prev;
  logic [ADDR_W-1:0]      cur;
  logic [LEVELS-1:0]      q_k;
  logic                   miss;
  logic [ID_W-1:0]        pdata;
  logic [ID_W-1:0]        rd_a;
  logic [ID_W-1:0]        rd_b;
  logic                   c1_vld;
  logic                   s1_vld;
  logic                   s2_vld;
  logic [ADDR_W-1:0]      v_d1;
  logic [ADDR_W-1:0]      v_d2;
  logic                   mid_zero;

  logic                   p_we;
  logic [ADDR_W-1:0]      p_waddr;
  logic [ID_W-1:0]        p_wdata;
  logic                   a_en;
  logic [ADDR_W+LVL_W-1:0] a_addr;
  logic                   w_en;
  logic [ADDR_W+LVL_W-1:0] w_addr;
  logic [ID_W-1:0]        w_data;
  logic                   node_ok;
  logic                   q_bad;

  assign lvl_prev = lvl - LVL_W'(1);
  assign node_ok  = (node != '0) && (32'(node) < NODES);
  assign q_bad    = !node_ok || ((32'(value) >> LEVELS) != 32'd0);

  assign p_we    = cmd.clr_wr | cmd.ld_wr;
  assign p_waddr = cmd.clr_wr ? cnt : ADDR_W'(node);
  assign p_wdata = (cmd.clr_wr || (32'(value) >= NODES)) ? '0 : value;

  always_ff @(posedge clk) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    if (cmd.copy_issue) begin
      pdata <= parent_mem[cnt];
    end
  end

  assign a_en   = cmd.lift_issue | cmd.walk_issue;
  assign a_addr = cmd.lift_issue ? {cnt, lvl_prev} : {cur, lvl};
  assign w_en   = c1_vld | s2_vld;
  assign w_addr = c1_vld ? {v_d1, lvl} : {v_d2, lvl};
  assign w_data = c1_vld ? pdata : (mid_zero ? '0 : rd_b);

  always_ff @(posedge clk) begin
    if (w_en) begin
      jt_mem[w_addr] <= w_data;
    end
    if (a_en) begin
      rd_a <= jt_mem[a_addr];
    end
    if (s1_vld) begin
      rd_b <= jt_mem[{ADDR_W'(rd_a), lvl_prev}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      lvl       <= '0;
      c1_vld    <= 1'b0;
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.cnt_clear) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + ADDR_W'(1);
      end
      if (cmd.lvl_clear) begin
        lvl <= '0;
      end else if (cmd.lvl_inc) begin
        lvl <= lvl + LVL_W'(1);
      end
      c1_vld <= cmd.copy_issue;
      s1_vld <= cmd.lift_issue;
      s2_vld <= s1_vld;
      if (cmd.result_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_issue || cmd.lift_issue) begin
      v_d1 <= cnt;
    end
    v_d2     <= v_d1;
    mid_zero <= (rd_a == '0);
    if (cmd.query_latch) begin
      cur  <= ADDR_W'(node);
      q_k  <= LEVELS'(value);
      miss <= q_bad;
    end else if (cmd.walk_take) begin
      cur <= ADDR_W'(rd_a);
      if (rd_a == '0) begin
        miss <= 1'b1;
      end
    end
    if (cmd.result_load) begin
      ancestor <= miss ? '0 : 16'(cur);
      found    <= !miss;
    end
  end

  assign sts.node_ok    = node_ok;
  assign sts.is_query   = op;
  assign sts.cnt_last   = (cnt == ADDR_W'(NODES - 1));
  assign sts.lvl_last   = (lvl == LVL_W'(LEVELS - 1));
  assign sts.pipe_empty = !c1_vld && !s1_vld && !s2_vld;
  assign sts.k_bit      = q_k[lvl];
  assign sts.miss       = miss;
  assign sts.rd_zero    = (rd_a == '0);
  assign sts.out_free   = !rsp_valid || !rsp_stall;

endmodule

`default_nettype wire

@@ src/kal_ctrl.sv @@
// ----------------------------------------------------------------------------
// kal_ctrl
// Controller: store clearing after reset, load/query dispatch, table
// rebuild sequencing, query walk and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module kal_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire kal_pkg::sts_t sts,
  output kal_pkg::cmd_t      cmd
);
  import kal_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_COPY   = 8'b0000_0100,
    S_LIFT   = 8'b0000_1000,
    S_DRAIN  = 8'b0001_0000,
    S_WALK   = 8'b0010_0000,
    S_WAIT   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   stale;
  logic   stale_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      stale <= 1'b1;
    end else begin
      state <= state_next;
      stale <= stale_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    stale_next = stale;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clear = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          if (!sts.is_query) begin
            if (sts.node_ok) begin
              cmd.ld_wr  = 1'b1;
              stale_next = 1'b1;
            end
          end else begin
            cmd.query_latch = 1'b1;
            cmd.lvl_clear   = 1'b1;
            cmd.cnt_clear   = 1'b1;
            state_next      = stale ? S_COPY : S_WALK;
          end
        end
      end
      S_COPY: begin
        cmd.copy_issue = 1'b1;
        cmd.cnt_inc    = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clear = 1'b1;
          state_next    = S_DRAIN;
        end
      end
      S_LIFT: begin
        cmd.lift_issue = 1'b1;
        cmd.cnt_inc    = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clear = 1'b1;
          state_next    = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          if (sts.lvl_last) begin
            cmd.lvl_clear = 1'b1;
            stale_next    = 1'b0;
            state_next    = S_WALK;
          end else begin
            cmd.lvl_inc = 1'b1;
            state_next  = S_LIFT;
          end
        end
      end
      S_WALK: begin
        if (sts.miss) begin
          state_next = S_FINISH;
        end else if (sts.k_bit) begin
          cmd.walk_issue = 1'b1;
          state_next     = S_WAIT;
        end else if (sts.lvl_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.lvl_inc = 1'b1;
        end
      end
      S_WAIT: begin
        cmd.walk_take = 1'b1;
        if (sts.rd_zero || sts.lvl_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.lvl_inc = 1'b1;
          state_next  = S_WALK;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
